FILE: hdl/dlbp_pkg.sv
`default_nettype none

package dlbp_pkg;

   // Widths fixed by the register and state layout
   localparam int unsigned TICK_W = 9;
   localparam int unsigned STEP_W = 8;

   // Configuration register indexes
   localparam logic [1:0] CSR_SPEED_MIN  = 2'd0;
   localparam logic [1:0] CSR_SPEED_MAX  = 2'd1;
   localparam logic [1:0] CSR_SPEED_STEP = 2'd2;

   // Reset values
   localparam logic [TICK_W-1:0] SPEED_MIN_RST  = 9'd30;
   localparam logic [TICK_W-1:0] SPEED_MAX_RST  = 9'd300;
   localparam logic [STEP_W-1:0] SPEED_STEP_RST = 8'd25;
   localparam logic [TICK_W-1:0] LIMIT_RST      = 9'd100;
   localparam logic [TICK_W-1:0] LIMIT_SAT      = 9'd511;

   // Drive levels of the two LEDs
   typedef struct packed {
      logic a;
      logic b;
   } led_pair_type;

   // Key levels of one item
   typedef struct packed {
      logic faster;
      logic slower;
      logic phase;
   } keys_type;

endpackage

`default_nettype wire

FILE: hdl/dlbp_level.sv
`default_nettype none

// Triangle-wave thresholds and on/off update of both LED levels
module dlbp_level #(
   parameter int unsigned PERIOD = 60
) (
   input  wire logic [$clog2(PERIOD)-1:0] cur,
   input  wire logic [$clog2(PERIOD)-1:0] fade,
   input  wire logic [$clog2(PERIOD)-1:0] phase,
   input  wire dlbp_pkg::led_pair_type    levels_old,
   output dlbp_pkg::led_pair_type         levels_new
);

   localparam int unsigned IDX_W = $clog2(PERIOD);
   localparam logic [IDX_W-1:0] HALF = IDX_W'(PERIOD / 2);

   function automatic logic [IDX_W-1:0] absdiff(input logic [IDX_W-1:0] x,
                                                input logic [IDX_W-1:0] y);
      absdiff = (x >= y) ? x - y : y - x;
   endfunction

   logic [IDX_W-1:0] thr_a;
   logic [IDX_W-1:0] thr_b;

   assign thr_a = absdiff(fade, HALF);
   assign thr_b = absdiff(absdiff(fade, phase), HALF);

   // Turn on at start of period, off at threshold; off wins
   always_comb begin
      levels_new = levels_old;
      if (cur == '0) begin
         levels_new.a = 1'b1;
         levels_new.b = 1'b1;
      end
      if (cur == thr_a) begin
         levels_new.a = 1'b0;
      end
      if (cur == thr_b) begin
         levels_new.b = 1'b0;
      end
   end

endmodule

`default_nettype wire

FILE: hdl/dual_led_breathing_pwm.sv
`default_nettype none

// Dual breathing-LED PWM. Each accepted req item is one tick carrying three key
// levels and yields one rsp item with the two LED drive levels. The tick
// counter, key edge detect, speed limit, fade index and phase update are done
// by one level of logic between the state registers and the rsp register, so
// an item is taken every cycle as long as the rsp register is free or being
// drained. Keys are only sampled when the tick counter passes the speed
// limit. csr writes are always ready and take effect immediately; write them
// only while the block is idle.
module dual_led_breathing_pwm #(
   parameter int unsigned PERIOD = 60
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic                        req_key_faster,
   input  wire logic                        req_key_slower,
   input  wire logic                        req_key_phase,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic                             rsp_led_a,
   output logic                             rsp_led_b,
   input  wire logic                        csr_valid,
   output logic                             csr_ready,
   input  wire logic [1:0]                  csr_index,
   input  wire logic [dlbp_pkg::TICK_W-1:0] csr_wdata
);

   localparam int unsigned IDX_W = $clog2(PERIOD);
   localparam int unsigned TW    = dlbp_pkg::TICK_W;
   localparam logic [IDX_W-1:0] LAST     = IDX_W'(PERIOD - 1);
   localparam logic [IDX_W-1:0] QUARTER  = IDX_W'(PERIOD / 4);
   localparam logic [IDX_W-1:0] FADE_RST = IDX_W'(1);

   // Configuration registers
   logic [TW-1:0]                 speed_min_ff;
   logic [TW-1:0]                 speed_max_ff;
   logic [dlbp_pkg::STEP_W-1:0]   speed_step_ff;

   // State
   logic [TW-1:0]              tick_ff,  tick_in;
   logic [IDX_W-1:0]           cur_ff,   cur_in;
   logic [TW-1:0]              limit_ff, limit_in;
   logic [IDX_W-1:0]           fade_ff,  fade_in;
   logic [IDX_W-1:0]           phase_ff, phase_in;
   dlbp_pkg::keys_type         prev_ff,  prev_in;
   dlbp_pkg::led_pair_type     levels_ff, levels_in;
   logic                       rsp_valid_ff, rsp_valid_in;

   dlbp_pkg::keys_type keys;
   logic               accept;
   logic [TW:0]        tick_next;
   logic               ovf;
   logic               edge_f, edge_s, edge_p;
   logic [TW:0]        limit_up;
   logic [TW-1:0]      limit_down;
   logic [IDX_W:0]     phase_sum;
   logic [IDX_W-1:0]   cur_step;

   assign keys      = '{faster: req_key_faster, slower: req_key_slower, phase: req_key_phase};
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;
   assign csr_ready = 1'b1;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         speed_min_ff  <= dlbp_pkg::SPEED_MIN_RST;
         speed_max_ff  <= dlbp_pkg::SPEED_MAX_RST;
         speed_step_ff <= dlbp_pkg::SPEED_STEP_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            dlbp_pkg::CSR_SPEED_MIN:  speed_min_ff  <= csr_wdata;
            dlbp_pkg::CSR_SPEED_MAX:  speed_max_ff  <= csr_wdata;
            dlbp_pkg::CSR_SPEED_STEP: speed_step_ff <= csr_wdata[dlbp_pkg::STEP_W-1:0];
            default: ;
         endcase
      end
   end

   // Tick counter overflow and key edges
   assign tick_next = {1'b0, tick_ff} + (TW+1)'(1);
   assign ovf       = tick_next > {1'b0, limit_ff};
   assign edge_f    = keys.faster & ~prev_ff.faster;
   assign edge_s    = keys.slower & ~prev_ff.slower;
   assign edge_p    = keys.phase  & ~prev_ff.phase;

   // Saturating limit steps and phase wrap
   assign limit_up   = {1'b0, limit_ff} + (TW+1)'(speed_step_ff);
   assign limit_down = (limit_ff >= TW'(speed_step_ff)) ? limit_ff - TW'(speed_step_ff) : '0;
   assign phase_sum  = {1'b0, phase_ff} + {1'b0, QUARTER};
   assign cur_step   = (cur_ff == LAST) ? '0 : cur_ff + IDX_W'(1);

   always_comb begin
      tick_in  = tick_next[TW-1:0];
      cur_in   = cur_step;
      limit_in = limit_ff;
      fade_in  = fade_ff;
      phase_in = phase_ff;
      prev_in  = prev_ff;
      if (ovf) begin
         tick_in = '0;
         cur_in  = '0;
         prev_in = keys;
         if (edge_f && (limit_ff > speed_min_ff)) begin
            limit_in = limit_down;
         end else if (edge_s && (limit_ff < speed_max_ff)) begin
            limit_in = limit_up[TW] ? dlbp_pkg::LIMIT_SAT : limit_up[TW-1:0];
         end else if (edge_p) begin
            phase_in = (phase_sum >= (IDX_W+1)'(PERIOD)) ?
                       IDX_W'(phase_sum - (IDX_W+1)'(PERIOD)) : phase_sum[IDX_W-1:0];
         end
         fade_in = (fade_ff == LAST) ? '0 : fade_ff + IDX_W'(1);
      end
   end

   // LED levels from the updated count, fade index and phase
   dlbp_level #(
      .PERIOD (PERIOD)
   ) u_level (
      .cur        (cur_in),
      .fade       (fade_in),
      .phase      (phase_in),
      .levels_old (levels_ff),
      .levels_new (levels_in)
   );

   // rsp register: loaded on accept, cleared when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // State update per accepted item
   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff      <= '0;
         cur_ff       <= '0;
         limit_ff     <= dlbp_pkg::LIMIT_RST;
         fade_ff      <= FADE_RST;
         phase_ff     <= QUARTER;
         prev_ff      <= '0;
         levels_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            tick_ff   <= tick_in;
            cur_ff    <= cur_in;
            limit_ff  <= limit_in;
            fade_ff   <= fade_in;
            phase_ff  <= phase_in;
            prev_ff   <= prev_in;
            levels_ff <= levels_in;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_led_a = levels_ff.a;
   assign rsp_led_b = levels_ff.b;

endmodule

`default_nettype wire

FILE: hdl/dlbp_checker.sv
`default_nettype none

// Port-level checks on the breathing-LED block
module dlbp_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_stall,
   input wire logic rsp_valid,
   input wire logic rsp_stall,
   input wire logic rsp_led_a,
   input wire logic rsp_led_b
);

   // No rsp item right after reset
   a_reset_empty: assert property (@(posedge clock)
      $fell(reset) |-> !rsp_valid)
      else $error("rsp_valid high right after reset");

   // Input only stalls while a rsp item is held back
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("req_stall without a held rsp item");

   // Every accepted item shows up as a rsp item next cycle
   a_item_out: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> rsp_valid)
      else $error("accepted item produced no rsp item");

   // A stalled rsp item stays and holds its levels
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_led_a) && $stable(rsp_led_b)))
      else $error("stalled rsp item changed");

endmodule

bind dual_led_breathing_pwm dlbp_checker u_dlbp_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_led_a (rsp_led_a),
   .rsp_led_b (rsp_led_b)
);

`default_nettype wire
